// File: design/jsu_pkg.sv
// Package for the JSON string unescape unit: phase and status codes,
// the command word passed from the front end to the back end, and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Depth of the command queue between front and back end
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_BS   = 3'd4,
    PH_U    = 3'd5,
    PH_HEX2 = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_BADESC  = 3'd3,
    ST_BADHEX  = 3'd4,
    ST_BADUNI  = 3'd5,
    ST_UNTERM  = 3'd6
  } status_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] CtrlLimit   = 8'h20;

  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [5:0]  HighSurTag = 6'b110110;
  localparam logic [5:0]  LowSurTag  = 6'b110111;

  // One command: either a single finished result (byte or status),
  // or a code point that the back end spreads over 1..4 UTF-8 bytes.
  typedef struct packed {
    logic        is_cp;
    logic [20:0] cp;
    logic [7:0]  data;
    status_e     status;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/jsu_in_if.sv
// Input channel of the JSON string unescape unit: one text byte per item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_string;
  logic       text_end;

  modport source(output valid, output in_byte, output start_of_string,
                 output text_end, input ready);
  modport sink(input valid, input in_byte, input start_of_string,
               input text_end, output ready);
endinterface

`default_nettype wire

// File: design/jsu_out_if.sv
// Output channel of the JSON string unescape unit: one decoded byte or status per item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source(output valid, output out_byte, output status, output last,
                 input ready);
  modport sink(input valid, input out_byte, input status, input last,
               output ready);
endinterface

`default_nettype wire

// File: design/jsu_front.sv
// Front end: accepts text bytes, runs the escape parser and issues commands.
// Depends on jsu_pkg and jsu_in_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire          clk_i,
  input  wire          rst_ni,
  jsu_in_if.sink       in_i,
  input  wire          q_full_i,
  output logic         push_o,
  output jsu_pkg::cmd_t cmd_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [15:0]     hex_q, hex_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [9:0]      hs_q, hs_d;

  logic            accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_IDLE;
      hex_q   <= '0;
      cnt_q   <= '0;
      hs_q    <= '0;
    end else begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
    end
  end

  always_comb begin
    jsu_pkg::phase_e ph;
    jsu_pkg::hex_t   hd;
    logic [7:0]      c;
    logic [15:0]     acc;

    phase_d = phase_q;
    hex_d   = hex_q;
    cnt_d   = cnt_q;
    hs_d    = hs_q;
    push_o  = 1'b0;
    cmd_o   = '{is_cp: 1'b0, cp: '0, data: '0, status: jsu_pkg::ST_BYTE};

    c   = in_i.in_byte;
    hd  = jsu_pkg::hex_digit(c);
    acc = {hex_q[11:0], hd.val};
    ph  = in_i.start_of_string ? jsu_pkg::PH_IDLE : phase_q;

    if (accept) begin
      phase_d = ph;
      if (in_i.text_end) begin
        // text ran out: no opening quote seen, or string left open
        push_o       = 1'b1;
        cmd_o.status = (ph == jsu_pkg::PH_IDLE) ? jsu_pkg::ST_NOQUOTE
                                                 : jsu_pkg::ST_UNTERM;
        phase_d      = jsu_pkg::PH_IDLE;
      end else begin
        unique case (ph)
          jsu_pkg::PH_IDLE: begin
            if (c != jsu_pkg::ChQuote) begin
              push_o       = 1'b1;
              cmd_o.status = jsu_pkg::ST_NOQUOTE;
            end else begin
              phase_d = jsu_pkg::PH_STR;
            end
          end
          jsu_pkg::PH_STR: begin
            priority if (c == jsu_pkg::ChBackslash) begin
              phase_d = jsu_pkg::PH_ESC;
            end else if (c == jsu_pkg::ChQuote) begin
              push_o       = 1'b1;
              cmd_o.status = jsu_pkg::ST_DONE;
              phase_d      = jsu_pkg::PH_IDLE;
            end else if (c < jsu_pkg::CtrlLimit) begin
              push_o       = 1'b1;
              cmd_o.status = jsu_pkg::ST_BADUNI;
              phase_d      = jsu_pkg::PH_IDLE;
            end else begin
              // raw bytes, high ones included, pass through unchanged
              push_o     = 1'b1;
              cmd_o.data = c;
            end
          end
          jsu_pkg::PH_ESC: begin
            push_o  = 1'b1;
            phase_d = jsu_pkg::PH_STR;
            unique case (c)
              jsu_pkg::ChQuote:     cmd_o.data = jsu_pkg::ChQuote;
              jsu_pkg::ChBackslash: cmd_o.data = jsu_pkg::ChBackslash;
              jsu_pkg::ChSlash:     cmd_o.data = jsu_pkg::ChSlash;
              jsu_pkg::ChLowerB:    cmd_o.data = 8'h08;
              jsu_pkg::ChLowerF:    cmd_o.data = 8'h0C;
              jsu_pkg::ChLowerN:    cmd_o.data = 8'h0A;
              jsu_pkg::ChLowerR:    cmd_o.data = 8'h0D;
              jsu_pkg::ChLowerT:    cmd_o.data = 8'h09;
              jsu_pkg::ChLowerU: begin
                push_o  = 1'b0;
                hex_d   = '0;
                cnt_d   = '0;
                phase_d = jsu_pkg::PH_HEX1;
              end
              default: begin
                cmd_o.status = jsu_pkg::ST_BADESC;
                phase_d      = jsu_pkg::PH_IDLE;
              end
            endcase
          end
          jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
            if (!hd.ok) begin
              push_o       = 1'b1;
              cmd_o.status = jsu_pkg::ST_BADHEX;
              phase_d      = jsu_pkg::PH_IDLE;
            end else begin
              hex_d = acc;
              if (cnt_q != 2'd3) begin
                cnt_d = cnt_q + 2'd1;
              end else begin
                cnt_d = '0;
                if (ph == jsu_pkg::PH_HEX1) begin
                  if (acc[15:10] == jsu_pkg::HighSurTag) begin
                    // hold the high half and wait for its partner
                    hs_d    = acc[9:0];
                    phase_d = jsu_pkg::PH_BS;
                  end else begin
                    push_o      = 1'b1;
                    cmd_o.is_cp = 1'b1;
                    cmd_o.cp    = {5'd0, acc};
                    phase_d     = jsu_pkg::PH_STR;
                  end
                end else if (acc[15:10] != jsu_pkg::LowSurTag) begin
                  push_o       = 1'b1;
                  cmd_o.status = jsu_pkg::ST_BADUNI;
                  phase_d      = jsu_pkg::PH_IDLE;
                end else begin
                  push_o      = 1'b1;
                  cmd_o.is_cp = 1'b1;
                  cmd_o.cp    = jsu_pkg::SuppBase + {1'b0, hs_q, acc[9:0]};
                  phase_d     = jsu_pkg::PH_STR;
                end
              end
            end
          end
          jsu_pkg::PH_BS: begin
            if (c != jsu_pkg::ChBackslash) begin
              push_o       = 1'b1;
              cmd_o.status = jsu_pkg::ST_BADUNI;
              phase_d      = jsu_pkg::PH_IDLE;
            end else begin
              phase_d = jsu_pkg::PH_U;
            end
          end
          jsu_pkg::PH_U: begin
            if (c != jsu_pkg::ChLowerU) begin
              push_o       = 1'b1;
              cmd_o.status = jsu_pkg::ST_BADUNI;
              phase_d      = jsu_pkg::PH_IDLE;
            end else begin
              hex_d   = '0;
              cnt_d   = '0;
              phase_d = jsu_pkg::PH_HEX2;
            end
          end
          default: begin
            phase_d = jsu_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // a low-surrogate phase is reached only through the expect-u phase
  a_hex2_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == jsu_pkg::PH_HEX2 && $past(phase_q) != jsu_pkg::PH_HEX2)
      |-> $past(phase_q) == jsu_pkg::PH_U)
    else $error("second hex phase entered from wrong phase");

  // a result is never issued while the queue is full
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("command issued into full queue");

endmodule

`default_nettype wire

// File: design/jsu_fifo.sv
// Command queue between the front end and the back end of the unescape unit.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::QueueDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  wire jsu_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire                pop_i,
  output logic               empty_o,
  output jsu_pkg::cmd_t      head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: design/jsu_back.sv
// Back end: takes commands from the queue and emits results, one byte each,
// expanding code points into UTF-8. Depends on jsu_pkg and jsu_out_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_empty_i,
  input  wire jsu_pkg::cmd_t head_i,
  output logic               pop_o,
  jsu_out_if.source          out_o
);

  logic            valid_q;
  logic [7:0]      bytes_q [4];
  logic [7:0]      bytes_d [4];
  jsu_pkg::status_e status_q;
  logic [1:0]      n_q, n_d;
  logic [1:0]      idx_q;
  logic            fire, at_last;

  assign at_last = (idx_q == n_q);
  assign fire    = valid_q && out_o.ready;
  assign pop_o   = !q_empty_i && (!valid_q || (fire && at_last));

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = bytes_q[idx_q];
  assign out_o.status   = status_q;
  assign out_o.last     = at_last;

  // UTF-8 encode the head command
  always_comb begin
    logic [20:0] cp;
    cp = head_i.cp;
    bytes_d[0] = head_i.data;
    bytes_d[1] = '0;
    bytes_d[2] = '0;
    bytes_d[3] = '0;
    n_d        = 2'd0;
    if (head_i.is_cp) begin
      priority if (cp[20:7] == '0) begin
        bytes_d[0] = {1'b0, cp[6:0]};
      end else if (cp[20:11] == '0) begin
        bytes_d[0] = {3'b110, cp[10:6]};
        bytes_d[1] = {2'b10, cp[5:0]};
        n_d        = 2'd1;
      end else if (cp[20:16] == '0) begin
        bytes_d[0] = {4'b1110, cp[15:12]};
        bytes_d[1] = {2'b10, cp[11:6]};
        bytes_d[2] = {2'b10, cp[5:0]};
        n_d        = 2'd2;
      end else begin
        bytes_d[0] = {5'b11110, cp[20:18]};
        bytes_d[1] = {2'b10, cp[17:12]};
        bytes_d[2] = {2'b10, cp[11:6]};
        bytes_d[3] = {2'b10, cp[5:0]};
        n_d        = 2'd3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q  <= bytes_d;
      status_q <= head_i.is_cp ? jsu_pkg::ST_BYTE : head_i.status;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else if (fire) begin
        if (at_last) begin
          valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // status results are always single
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != jsu_pkg::ST_BYTE) |-> n_q == 2'd0)
    else $error("status result spans several bytes");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= n_q)
    else $error("byte index past end of code point");

endmodule

`default_nettype wire

// File: design/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescape unit with UTF-8 output.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_fifo, jsu_back.
//
// Usage:
//   in_i  carries one text byte per item, with start_of_string marking the
//         byte that should be the opening quote and text_end marking the end
//         of the text (its byte is then ignored).
//   out_o carries one result per item: a decoded byte (status 0), a done
//         mark at the closing quote, or an error status; last flags the
//         final result caused by one input byte.
// Timing:
//   The front end parses one byte per cycle while the queue has room and
//   posts at most one command into a small queue; the back end turns each
//   command into 1..4 results. With the queue empty and the output free,
//   a command is written into the queue and then loaded into the output
//   register before its first result is valid. Throughput is one input
//   byte per cycle; a code point holds the output for each of its UTF-8 bytes
//   (up to 4), which the queue absorbs until it fills and in_i.ready drops.
// Reset:
//   Clears the parser to idle and empties the queue and output stage.
// Stalls:
//   When out_o.ready is low the current result holds; the queue keeps
//   taking bytes until it is full.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_unit #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QueueDepth
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic          push, pop, q_full, q_empty;
  jsu_pkg::cmd_t cmd, head;

  // parse bytes and issue commands
  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  // decouple parser from output stalls
  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // expand commands into output bytes
  jsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for json_string_unescape_utf8_unit: drives JSON string bytes,
// predicts the decoded UTF-8 bytes and status items, and checks each result item.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the unit itself.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  // Run limits: generous over the slowest legal run
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomItems = 210;
  localparam int unsigned IdlePercent = 32;
  localparam int unsigned ReportLimit = 10;

  // Simple escape letters, in the order the unit accepts them
  localparam logic [7:0] EscLetters [8] = '{ChQuote, ChBackslash, ChSlash, ChLowerB,
                                            ChLowerF, ChLowerN, ChLowerR, ChLowerT};

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_utf8_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder state of the predictor
  // ---------------------------------------------------------------------------
  phase_e      str_phase  = PH_IDLE;
  logic [15:0] hex_acc    = '0;
  logic [1:0]  hex_digits = '0;
  logic [9:0]  high_half  = '0;

  result_t     decoded_results[$];   // expected result items, oldest first
  result_t     batch_q[$];           // result items of the current input item

  int unsigned items_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  bit          send_idle    = 1'b0;
  bit          recv_idle    = 1'b0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;
  result_t     want;

  // Append one result item to the batch of the current input item
  function automatic void add_result(input logic [7:0] d, input status_e s);
    result_t r;
    r.data   = d;
    r.status = s;
    r.last   = 1'b0;
    batch_q  = {batch_q, r};
  endfunction

  // Advance the decoder by one accepted input item and queue the result items
  // it causes. The last of them carries the last flag.
  function automatic void decode_byte(input logic [7:0] c, input logic sos, input logic te);
    logic [3:0]  nib;
    logic        is_hex;
    logic [20:0] cp;
    logic        have_cp;
    logic        have_err;
    status_e     err;
    batch_q.delete();
    have_cp  = 1'b0;
    have_err = 1'b0;
    err      = ST_BYTE;
    cp       = '0;
    nib      = '0;
    is_hex   = 1'b1;

    // A start mark drops any string in progress without a result
    if (sos) str_phase = PH_IDLE;

    if (te) begin
      have_err = 1'b1;
      err      = (str_phase == PH_IDLE) ? ST_NOQUOTE : ST_UNTERM;
    end else begin
      case (str_phase)
        PH_IDLE: begin
          if (c != ChQuote) begin
            have_err = 1'b1;
            err      = ST_NOQUOTE;
          end else begin
            str_phase = PH_STR;
          end
        end
        PH_STR: begin
          if (c == ChBackslash) begin
            str_phase = PH_ESC;
          end else if (c == ChQuote) begin
            str_phase = PH_IDLE;
            add_result(8'h00, ST_DONE);
          end else if (c < CtrlLimit) begin
            have_err = 1'b1;
            err      = ST_BADUNI;
          end else begin
            // high bytes pass through untouched
            add_result(c, ST_BYTE);
          end
        end
        PH_ESC: begin
          str_phase = PH_STR;
          case (c)
            ChQuote, ChBackslash, ChSlash: add_result(c, ST_BYTE);
            ChLowerB: add_result(8'h08, ST_BYTE);
            ChLowerF: add_result(8'h0C, ST_BYTE);
            ChLowerN: add_result(8'h0A, ST_BYTE);
            ChLowerR: add_result(8'h0D, ST_BYTE);
            ChLowerT: add_result(8'h09, ST_BYTE);
            ChLowerU: begin
              hex_acc    = '0;
              hex_digits = '0;
              str_phase  = PH_HEX1;
            end
            default: begin
              have_err = 1'b1;
              err      = ST_BADESC;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else is_hex = 1'b0;

          if (!is_hex) begin
            have_err = 1'b1;
            err      = ST_BADHEX;
          end else begin
            hex_acc = {hex_acc[11:0], nib};
            if (hex_digits != 2'd3) begin
              hex_digits = hex_digits + 2'd1;
            end else begin
              hex_digits = '0;
              if (str_phase == PH_HEX1) begin
                if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                  // hold the high surrogate and wait for its low half
                  high_half = 10'(hex_acc - 16'hD800);
                  str_phase = PH_BS;
                end else begin
                  have_cp = 1'b1;
                  cp      = 21'(hex_acc);
                end
              end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                have_err = 1'b1;
                err      = ST_BADUNI;
              end else begin
                have_cp = 1'b1;
                cp      = 21'h10000 + {1'b0, high_half, 10'd0} + 21'(hex_acc - 16'hDC00);
              end
            end
          end
        end
        PH_BS: begin
          if (c != ChBackslash) begin
            have_err = 1'b1;
            err      = ST_BADUNI;
          end else begin
            str_phase = PH_U;
          end
        end
        PH_U: begin
          if (c != ChLowerU) begin
            have_err = 1'b1;
            err      = ST_BADUNI;
          end else begin
            hex_acc    = '0;
            hex_digits = '0;
            str_phase  = PH_HEX2;
          end
        end
        default: str_phase = PH_IDLE;
      endcase
    end

    if (have_err) begin
      str_phase = PH_IDLE;
      add_result(8'h00, err);
    end

    // Spread the code point over one to four UTF-8 bytes
    if (have_cp) begin
      str_phase = PH_STR;
      if (cp <= 21'h7F) begin
        add_result(cp[7:0], ST_BYTE);
      end else if (cp <= 21'h7FF) begin
        add_result({3'b110, cp[10:6]}, ST_BYTE);
        add_result({2'b10, cp[5:0]}, ST_BYTE);
      end else if (cp <= 21'hFFFF) begin
        add_result({4'b1110, cp[15:12]}, ST_BYTE);
        add_result({2'b10, cp[11:6]}, ST_BYTE);
        add_result({2'b10, cp[5:0]}, ST_BYTE);
      end else begin
        add_result({5'b11110, cp[20:18]}, ST_BYTE);
        add_result({2'b10, cp[17:12]}, ST_BYTE);
        add_result({2'b10, cp[11:6]}, ST_BYTE);
        add_result({2'b10, cp[5:0]}, ST_BYTE);
      end
    end

    if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
    foreach (batch_q[i]) decoded_results = {decoded_results, batch_q[i]};
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item, idling at random first, and hold it until accepted.
  task automatic send_item(input logic [7:0] b, input logic sos = 1'b0,
                           input logic te = 1'b0);
    while (send_idle && $urandom_range(0, 99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.in_byte         <= b;
    in_if.start_of_string <= sos;
    in_if.text_end        <= te;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, sos, te);
    items_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    // mix letter case
    return 8'(($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10));
  endfunction

  // Send \u followed by four hex digits
  task automatic send_u(input logic [15:0] v);
    send_item(ChBackslash);
    send_item(ChLowerU);
    for (int i = 3; i >= 0; i--) send_item(hex_char(v[i*4 +: 4]));
  endtask

  // Send a supplementary code point as a surrogate pair
  task automatic send_pair(input logic [20:0] cp);
    logic [19:0] off;
    off = 20'(cp - 21'h10000);
    send_u(16'hD800 + 16'(off[19:10]));
    send_u(16'hDC00 + 16'(off[9:0]));
  endtask

  task automatic send_random_string();
    int          n;
    int          kind;
    logic [7:0]  b;
    logic [15:0] v;
    send_item(ChQuote, $urandom_range(0, 9) != 0);
    n = $urandom_range(0, 10);
    repeat (n) begin
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        // keep the string open: move a quote or backslash into the high half
        if (b == ChQuote || b == ChBackslash) b = b ^ 8'h80;
        send_item(b);
      end else if (kind < 10) begin
        send_item(ChBackslash);
        send_item(EscLetters[$urandom_range(0, 7)]);
      end else if (kind < 15) begin
        case ($urandom_range(0, 2))
          0:       v = 16'($urandom_range(0, 16'h7F));
          1:       v = 16'($urandom_range(16'h80, 16'h7FF));
          default: v = 16'($urandom_range(16'h800, 16'hFFFF));
        endcase
        // a high half here would need a pair; turn it into a lone low half
        if (v[15:10] == HighSurTag) v[10] = 1'b1;
        send_u(v);
      end else if (kind < 18) begin
        send_pair(21'($urandom_range(21'h10000, 21'h10FFFF)));
      end else if (kind == 18) begin
        // broken escape: any byte after the backslash
        send_item(ChBackslash);
        send_item(8'($urandom_range(0, 255)));
      end else begin
        send_item(8'($urandom_range(0, 255)));
      end
    end
    kind = $urandom_range(0, 19);
    if (kind < 16) send_item(ChQuote);
    else if (kind < 18) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    // else leave it open; the next start mark drops it
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls plus long hold-offs on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(recv_idle && $urandom_range(0, 99) < IdlePercent);
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (decoded_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: unexpected result: byte %02h status %0d last %0b",
                   $realtime, out_if.out_byte, out_if.status, out_if.last);
      end else begin
        want = decoded_results.pop_front();
        if (out_if.out_byte !== want.data || out_if.status !== want.status ||
            out_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display({"%0t: mismatch: expected byte %02h status %s last %0b,",
                      " got byte %02h status %0d last %0b"},
                     $realtime, want.data, want.status.name(), want.last,
                     out_if.out_byte, out_if.status, out_if.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Opening quote checks, text end, start mark, raw bytes and control bytes
  task automatic test_framing();
    send_item("A", 1'b1);               // idle byte that is not a quote
    send_item(8'hFF, 1'b0, 1'b1);       // text end while idle
    send_item(ChQuote, 1'b1);
    send_item("x");
    send_item(ChQuote, 1'b1);           // start mark drops the open string
    send_item(8'h80);
    send_item(8'hFF);
    send_item(CtrlLimit);
    send_item(8'h00, 1'b0, 1'b1);       // text end inside the string
    send_item(ChQuote, 1'b1);
    send_item(8'h1F);                   // control byte
    send_item(ChQuote, 1'b1);
    send_item(8'h00);                   // lowest control byte
  endtask

  // Every simple escape, then an unknown one
  task automatic test_escapes();
    send_item(ChQuote, 1'b1);
    foreach (EscLetters[i]) begin
      send_item(ChBackslash);
      send_item(EscLetters[i]);
    end
    send_item(ChQuote);
    send_item(ChQuote, 1'b1);
    send_item(ChBackslash);
    send_item("q");
  endtask

  // Code points at each UTF-8 length boundary, the null escape, pairs, lone low half
  task automatic test_unicode();
    send_item(ChQuote, 1'b1);
    send_u(16'h0000);
    send_u(16'h007F);
    send_u(16'h0080);
    send_u(16'h07FF);
    send_u(16'h0800);
    send_u(16'hFFFF);
    send_pair(21'h10000);
    send_pair(21'h10FFFF);
    send_u(16'hDC00);
    send_u(16'hDFFF);
    send_u(16'hABCD);
    send_item(ChQuote);
  endtask

  // Bad hex digit, missing or wrong low surrogate, end inside an escape
  task automatic test_unicode_errors();
    send_item(ChQuote, 1'b1);
    send_item(ChBackslash);
    send_item(ChLowerU);
    send_item("1");
    send_item("g");
    send_item(ChQuote, 1'b1);
    send_u(16'hD800);
    send_item("x");                     // no backslash after the high half
    send_item(ChQuote, 1'b1);
    send_u(16'hDBFF);
    send_item(ChBackslash);
    send_item(ChLowerN);                // backslash but not u
    send_item(ChQuote, 1'b1);
    send_u(16'hD800);
    send_u(16'h0041);                   // second half outside the low range
    send_item(ChQuote, 1'b1);
    send_u(16'hD800);
    send_u(16'hE000);
    send_item(ChQuote, 1'b1);
    send_u(16'hD801);
    send_item(ChQuote);                 // closing quote where a low half belongs
    send_item(ChQuote, 1'b1);
    send_item(ChBackslash);
    send_item(ChLowerU);
    send_item("F");
    send_item(8'h00, 1'b0, 1'b1);       // text end in the middle of the digits
  endtask

  // Mostly well-formed strings with random content, plus loose noise items
  task automatic test_random();
    int unsigned first;
    first = items_sent;
    // open with a stretch of no idling on either side
    send_idle <= 1'b0;
    recv_idle <= 1'b0;
    while (items_sent - first < RandomItems) begin
      if (!send_idle && items_sent - first >= 100) begin
        send_idle <= 1'b1;
        recv_idle <= 1'b1;
      end
      if ($urandom_range(0, 4) == 0)
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 7) == 0);
      else
        send_random_string();
    end
  endtask

  // Hold the receiver off while four-byte code points keep coming, so the
  // queue fills and the input stalls.
  task automatic test_backpressure();
    send_idle   <= 1'b0;
    holds_asked <= holds_asked + 1;
    send_item(ChQuote, 1'b1);
    repeat (8) send_pair(21'($urandom_range(21'h10000, 21'h10FFFF)));
    send_item(ChQuote);
    send_idle <= 1'b1;
  endtask

  initial begin
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.in_byte         <= 8'h00;
    in_if.start_of_string <= 1'b0;
    in_if.text_end        <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni    <= 1'b1;
    send_idle <= 1'b1;
    recv_idle <= 1'b1;
    @(posedge clk_i);

    test_framing();
    test_escapes();
    test_unicode();
    test_unicode_errors();
    test_random();
    test_backpressure();

    in_if.valid <= 1'b0;
    // drain what is still expected, then watch for stray items
    while (decoded_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
